// ===== rtl/aabb_frustum_cull_defines.svh =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_defines
// Assertion macros shared by the box culling RTL.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// check a property on clk, off while rst_n is low
`define AFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition never holds out of reset
`define AFC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// Types, widths and codes of the box culling block.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int COORD_WIDTH = 16;
    localparam int REG_COUNT   = 6;
    localparam int FIELD_WIDTH = 16;
    localparam int NORMAL_FRAC = 14;
    localparam int AXES        = 3;

    localparam int ADDR_WIDTH  = 6;
    localparam int REG_IDX_W   = ADDR_WIDTH - 3;
    localparam int DATA_WIDTH  = 64;

    localparam int PROD_W = COORD_WIDTH + FIELD_WIDTH;
    localparam int OFFS_W = FIELD_WIDTH + NORMAL_FRAC;
    localparam int SUM_W  = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [FIELD_WIDTH-1:0] field_t;

    typedef struct packed {
        field_t d;
        field_t nz;
        field_t ny;
        field_t nx;
    } plane_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_WIDTH-1:0] hi;
        logic [AXES-1:0][COORD_WIDTH-1:0] lo;
    } box_t;

    typedef struct packed {
        logic outside;
        logic partial;
    } plane_flags_t;

    typedef enum logic [1:0] {
        VIS_INSIDE  = 2'd0,
        VIS_CLIPPED = 2'd1,
        VIS_OUTSIDE = 2'd2
    } vis_t;

endpackage

// ===== rtl/afc_plane_eval.sv =====
// ----------------------------------------------------------------------------
// afc_plane_eval
// Two-stage test of one box against one plane: vertex select and products,
// then the dot-product sums and their sign.
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_defines.svh"

module afc_plane_eval (
    input  logic                  clk,
    input  logic                  rst_n,
    input  afc_pkg::box_t         box,
    input  afc_pkg::plane_t       plane,
    output afc_pkg::plane_flags_t flags
);
    import afc_pkg::*;

    field_t                  nc [AXES];
    logic                    pos [AXES];
    logic signed [PROD_W-1:0] prod_p_next [AXES];
    logic signed [PROD_W-1:0] prod_n_next [AXES];
    logic signed [PROD_W-1:0] prod_p_reg  [AXES];
    logic signed [PROD_W-1:0] prod_n_reg  [AXES];
    logic signed [OFFS_W-1:0] offs_next;
    logic signed [OFFS_W-1:0] offs_reg;
    logic signed [SUM_W-1:0]  sum_p;
    logic signed [SUM_W-1:0]  sum_n;
    plane_flags_t             flags_next;
    plane_flags_t             flags_reg;

    assign nc[0] = plane.nx;
    assign nc[1] = plane.ny;
    assign nc[2] = plane.nz;

    // pick p and n vertices per axis, multiply
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            coord_t c_lo;
            coord_t c_hi;
            c_lo = coord_t'(box.lo[a]);
            c_hi = coord_t'(box.hi[a]);
            pos[a] = !nc[a][FIELD_WIDTH-1] && (|nc[a]);
            if (pos[a])
            begin
                prod_p_next[a] = c_hi * nc[a];
                prod_n_next[a] = c_lo * nc[a];
            end
            else
            begin
                prod_p_next[a] = c_lo * nc[a];
                prod_n_next[a] = c_hi * nc[a];
            end
        end
        offs_next = {plane.d, {NORMAL_FRAC{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prod_p_reg[a] <= '0;
                prod_n_reg[a] <= '0;
            end
            offs_reg <= '0;
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prod_p_reg[a] <= prod_p_next[a];
                prod_n_reg[a] <= prod_n_next[a];
            end
            offs_reg <= offs_next;
        end
    end

    always_comb
    begin
        sum_p = SUM_W'(offs_reg) + SUM_W'(prod_p_reg[0])
              + SUM_W'(prod_p_reg[1]) + SUM_W'(prod_p_reg[2]);
        sum_n = SUM_W'(offs_reg) + SUM_W'(prod_n_reg[0])
              + SUM_W'(prod_n_reg[1]) + SUM_W'(prod_n_reg[2]);
        flags_next.partial = !sum_p[SUM_W-1] && (|sum_p);
        flags_next.outside = !sum_n[SUM_W-1] && (|sum_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

    `AFC_NEVER(a_flags_known, $isunknown(flags_reg), "plane flags unknown")
    `AFC_ASSERT(a_zero_plane_no_clip, ($past(plane) == '0) && $stable(plane) |=> ##1 !flags_reg.partial, "zero plane clipped")
    `AFC_ASSERT(a_zero_normal_offs, ($past(plane.nx) == '0) && ($past(plane.ny) == '0) && ($past(plane.nz) == '0) |-> (flags_next.partial == flags_next.outside), "zero normal flags differ")

endmodule

// ===== rtl/aabb_frustum_cull.sv =====
// Flow: a box accepted on start passes the capture, product, plane-flag and
//   result registers; done marks the cycle in which its result is on visibility.
// Throughput: one box per cycle; busy stays low, set by the four-stage pipe
//   (capture, products, plane sums, class merge).
// Reset: clears the pipe valid bits, the capture and plane-test registers and
//   all plane registers to zero.
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Classifies axis-aligned boxes against the frustum planes held in the APB
// register file: fully inside, partly clipped or not visible.
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_defines.svh"

module aabb_frustum_cull (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_min_x,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_min_y,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_min_z,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_max_x,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_max_y,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] box_max_z,
    output logic                            done,
    output logic [1:0]                      visibility,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [afc_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [afc_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [afc_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready
);
    import afc_pkg::*;

    logic                  accept;
    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  reg_idx;
    plane_t                plane_reg [PLANE_COUNT];
    box_t                  box_next;
    box_t                  box_reg;
    logic                  s1_valid_reg;
    logic                  s2_valid_reg;
    logic                  s3_valid_reg;
    logic                  done_reg;
    plane_flags_t          flags [PLANE_COUNT];
    logic                  any_outside;
    logic                  any_partial;
    vis_t                  vis_next;
    vis_t                  vis_reg;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_WIDTH-1:3];

    // plane register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PLANE_COUNT; k++)
            begin
                plane_reg[k] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            for (int k = 0; k < PLANE_COUNT; k++)
            begin
                if (k < REG_COUNT && reg_idx == REG_IDX_W'(k))
                begin
                    plane_reg[k] <= plane_t'(pwdata);
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            if (k < REG_COUNT && reg_idx == REG_IDX_W'(k))
            begin
                prdata = DATA_WIDTH'(plane_reg[k]);
            end
        end
    end

    // capture stage
    assign box_next.lo[0] = box_min_x;
    assign box_next.lo[1] = box_min_y;
    assign box_next.lo[2] = box_min_z;
    assign box_next.hi[0] = box_max_x;
    assign box_next.hi[1] = box_max_y;
    assign box_next.hi[2] = box_max_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else if (accept)
        begin
            box_reg <= box_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    for (genvar k = 0; k < PLANE_COUNT; k++)
    begin : g_plane
        afc_plane_eval u_eval (
            .clk   (clk),
            .rst_n (rst_n),
            .box   (box_reg),
            .plane (plane_reg[k]),
            .flags (flags[k])
        );
    end

    // merge plane results
    always_comb
    begin
        any_outside = 1'b0;
        any_partial = 1'b0;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            any_outside = any_outside | flags[k].outside;
            any_partial = any_partial | flags[k].partial;
        end
        if (any_outside)
        begin
            vis_next = VIS_OUTSIDE;
        end
        else if (any_partial)
        begin
            vis_next = VIS_CLIPPED;
        end
        else
        begin
            vis_next = VIS_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            vis_reg <= vis_next;
        end
    end

    assign done       = done_reg;
    assign visibility = vis_reg;

    `AFC_ASSERT(a_accept_to_done, accept |-> ##4 done, "accepted box produced no result")
    `AFC_ASSERT(a_done_from_accept, done |-> $past(accept, 4), "result without a box")
    `AFC_ASSERT(a_vis_code, done |-> (visibility == VIS_INSIDE || visibility == VIS_CLIPPED || visibility == VIS_OUTSIDE), "bad visibility code")

endmodule
